@@ rtl/core/lss_pkg.sv @@
package lss_pkg;

    localparam int MaxRequests = 64;
    localparam int TrackBits   = 16;
    localparam int IdxBits     = $clog2(MaxRequests);
    localparam int CntBits     = $clog2(MaxRequests + 1);
    localparam int TotalBits   = 17;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] track;
        logic [15:0] head_track;
        logic [15:0] prev_track;
    } t_in_item;

    typedef struct packed {
        logic [15:0] served_track;
        logic [16:0] seek_total;
        logic        last;
        logic        empty_res;
        logic        dropped;
    } t_out_item;

    // Run command passed from front to back
    typedef struct packed {
        logic [TrackBits-1:0] head;
        logic                 upward;
        logic [CntBits-1:0]   count;
        logic                 dropped;
    } t_run_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_DONE
    } t_back_state;

endpackage

@@ rtl/core/lss_ram.sv @@
module lss_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/core/lss_front.sv @@
module lss_front import lss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    // store write port
    output logic                 o_we,
    output logic [IdxBits-1:0]   o_waddr,
    output logic [TrackBits-1:0] o_wdata,
    // one-entry command queue to back
    output logic                 o_cmd_valid,
    output t_run_cmd             o_cmd,
    input  logic                 i_cmd_take,
    input  logic                 i_back_idle
);
    logic [CntBits-1:0] r_count;
    logic               r_ovf;
    logic               r_cmd_valid;
    t_run_cmd           r_cmd;
    logic               w_acc;

    // Input waits while a run is queued or still reading the store
    assign o_ready = !r_cmd_valid && i_back_idle;
    assign w_acc   = i_valid && o_ready;
    assign o_we    = w_acc && (i_item.kind == KIND_LOAD) && (r_count < CntBits'(MaxRequests));
    assign o_waddr = r_count[IdxBits-1:0];
    assign o_wdata = i_item.track[TrackBits-1:0];
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (i_cmd_take) begin
                r_cmd_valid <= 1'b0;
            end
            if (w_acc) begin
                if (i_item.kind == KIND_LOAD) begin
                    if (o_we) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end else begin
                    r_cmd_valid <= 1'b1;
                    r_count     <= '0;
                    r_ovf       <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_item.kind == KIND_RUN) begin
            r_cmd.head    <= i_item.head_track[TrackBits-1:0];
            r_cmd.upward  <= i_item.prev_track[TrackBits-1:0]
                             <= i_item.head_track[TrackBits-1:0];
            r_cmd.count   <= r_count;
            r_cmd.dropped <= r_ovf;
        end
    end
endmodule

@@ rtl/core/lss_back.sv @@
module lss_back import lss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_run_cmd             i_cmd,
    output logic                 o_cmd_take,
    output logic                 o_idle,
    output logic [IdxBits-1:0]   o_raddr,
    input  logic [TrackBits-1:0] i_rdata,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_item
);
    // Each emit is a selection scan: find the next track in LOOK order
    // greater (or smaller) than the last served one, with tie handling by index.
    t_back_state          r_state, n_state;
    t_run_cmd             r_cmd;
    logic [IdxBits-1:0]   r_idx;     // scan pointer
    logic                 r_rvalid;  // i_rdata holds valid read data
    logic [IdxBits-1:0]   r_ridx;
    logic [CntBits-1:0]   r_served;
    logic [TrackBits-1:0] r_pos;
    logic [16:0]          r_total;
    // last served key (phase, track, index) for ordering
    logic                 r_have_last;
    logic [TrackBits+1:0] r_last_key;
    logic [IdxBits-1:0]   r_last_idx;
    logic                 r_have_best;
    logic [TrackBits+1:0] r_best_key;
    logic [IdxBits-1:0]   r_best_idx;
    logic [TrackBits-1:0] r_best_trk;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic [TrackBits+1:0] w_key;
    logic                 w_after_last, w_better, w_scan_end;
    logic [TrackBits:0]   w_dist;
    logic [TotalBits:0]   w_sum;

    // Ordering key: first group 0, second group 1; descending groups invert track
    always_comb begin
        logic upper;
        upper = i_rdata > r_cmd.head;
        if (upper) begin
            w_key = {~r_cmd.upward, 1'b0, i_rdata};
        end else begin
            w_key = {r_cmd.upward, 1'b0, ~i_rdata};
        end
    end

    assign w_after_last = !r_have_last || (w_key > r_last_key)
                          || (w_key == r_last_key && r_ridx > r_last_idx);
    assign w_better   = !r_have_best || (w_key < r_best_key);
    assign w_scan_end = r_rvalid && ({1'b0, r_ridx} == r_cmd.count - 1'b1);
    assign w_dist = (r_best_trk > r_pos) ? {1'b0, r_best_trk - r_pos}
                                         : {1'b0, r_pos - r_best_trk};
    assign w_sum  = {1'b0, r_total} + (TotalBits + 1)'(w_dist);

    assign o_raddr    = r_idx;
    assign o_cmd_take = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_idle     = (r_state == ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_cmd_valid) begin
                n_state = (i_cmd.count == '0) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: if (w_scan_end) n_state = ST_EMIT;
            ST_EMIT: if (!r_out_valid || i_ready) begin
                n_state = (r_served + 1'b1 == r_cmd.count) ? ST_IDLE : ST_SCAN;
            end
            ST_DONE: if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rvalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            r_rvalid <= (r_state == ST_SCAN) && !w_scan_end
                        && ({1'b0, r_idx} < r_cmd.count) && !(r_rvalid && w_scan_end);
            if ((r_state == ST_EMIT || r_state == ST_DONE) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_cmd       <= i_cmd;
                r_idx       <= '0;
                r_served    <= '0;
                r_pos       <= i_cmd.head;
                r_total     <= '0;
                r_have_last <= 1'b0;
                r_have_best <= 1'b0;
            end
            ST_SCAN: begin
                if (({1'b0, r_idx} < r_cmd.count) && !r_rvalid || r_rvalid && !w_scan_end) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_ridx <= r_idx;
                if (r_rvalid && w_after_last && w_better) begin
                    r_have_best <= 1'b1;
                    r_best_key  <= w_key;
                    r_best_idx  <= r_ridx;
                    r_best_trk  <= i_rdata;
                end
            end
            ST_EMIT: if (!r_out_valid || i_ready) begin
                r_out.served_track <= 16'(r_best_trk);
                r_out.seek_total   <= w_sum > (TotalBits + 1)'(131071) ? 17'h1FFFF
                                                                      : w_sum[16:0];
                r_out.last         <= (r_served + 1'b1 == r_cmd.count);
                r_out.empty_res    <= 1'b0;
                r_out.dropped      <= r_cmd.dropped;
                r_total     <= w_sum > (TotalBits + 1)'(131071) ? 17'h1FFFF : w_sum[16:0];
                r_pos       <= r_best_trk;
                r_served    <= r_served + 1'b1;
                r_have_last <= 1'b1;
                r_last_key  <= r_best_key;
                r_last_idx  <= r_best_idx;
                r_have_best <= 1'b0;
                r_idx       <= '0;
            end
            ST_DONE: if (!r_out_valid || i_ready) begin
                r_out.served_track <= '0;
                r_out.seek_total   <= '0;
                r_out.last         <= 1'b1;
                r_out.empty_res    <= 1'b1;
                r_out.dropped      <= r_cmd.dropped;
            end
            default: ;
        endcase
    end

    // Checks
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out))
        else $error("result changed while stalled");
    a_emit_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_have_best)
        else $error("emit without a selected request");
    a_served_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_served < r_cmd.count)
        else $error("served count beyond run length");
endmodule

@@ rtl/core/look_seek_scheduler_top.sv @@
// channel | direction | handshake            | payload
// input   | in        | i_valid / o_ready    | i_item (t_in_item)
// output  | out       | o_valid / i_ready    | o_item (t_out_item)
// An accepted load goes into the store unless it is full. A run is handed
// over from front to back; each result is then a scan through the single
// registered read port and an emit step. An empty run gives one empty result.
// Reset is synchronous, active low, and clears control and the load count only.
// Input stalls from a run's acceptance until the back end is idle again, so
// the store is never rewritten mid-run; an output stall holds the emit step.
module look_seek_scheduler_top import lss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    logic                 w_we;
    logic [IdxBits-1:0]   w_waddr, w_raddr;
    logic [TrackBits-1:0] w_wdata, w_rdata;
    logic                 w_cmd_valid, w_cmd_take, w_back_idle;
    t_run_cmd             w_cmd;

    lss_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_we(w_we), .o_waddr(w_waddr), .o_wdata(w_wdata),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take),
        .i_back_idle(w_back_idle)
    );

    lss_ram #(.Width(TrackBits), .Depth(MaxRequests)) u_ram (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    lss_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_cmd_take), .o_idle(w_back_idle), .o_raddr(w_raddr),
        .i_rdata(w_rdata), .o_valid, .i_ready, .o_item
    );
endmodule
